FILE: rtl/nvps_pkg.sv
package nvps_pkg;

    localparam int PAGE_NUMBER_BITS_DEF = 20;
    localparam int VICTIM_PAGE_BITS     = 20;
    localparam int PID_BITS             = 16;
    localparam int ENTRY_BITS           = 32;
    localparam int STATE_BITS           = 3;
    localparam int NUM_CLASSES          = 4;
    localparam int CLASS_BITS           = 2;

    localparam logic [PID_BITS-1:0] RESERVED_PID_RESET = 16'd5;

    localparam logic [STATE_BITS-1:0] ST_UNUSED  = 3'd0;
    localparam logic [STATE_BITS-1:0] ST_EMBRYO  = 3'd1;
    localparam logic [STATE_BITS-1:0] ST_RUNNING = 3'd4;

    localparam int ENT_PRESENT_BIT  = 0;
    localparam int ENT_USER_BIT     = 2;
    localparam int ENT_ACCESSED_BIT = 5;
    localparam int ENT_DIRTY_BIT    = 6;
    localparam int ENT_SWAPPED_BIT  = 7;

    typedef struct packed {
        logic                  eligible;
        logic [CLASS_BITS-1:0] cls;
    } filt_t;

endpackage

FILE: rtl/nvps_if.sv
interface nvps_scan_if #(
    parameter int PAGE_BITS = nvps_pkg::PAGE_NUMBER_BITS_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic [nvps_pkg::PID_BITS-1:0]        owner_pid;
    logic [nvps_pkg::STATE_BITS-1:0]      owner_state;
    logic [PAGE_BITS-1:0]                 page_number;
    logic [nvps_pkg::ENTRY_BITS-1:0]      entry_word;
    logic [nvps_pkg::PID_BITS-1:0]        requester_pid;
    logic                                 last;

    modport source (
        output valid, owner_pid, owner_state, page_number, entry_word, requester_pid, last,
        input  ready
    );
    modport sink (
        input  valid, owner_pid, owner_state, page_number, entry_word, requester_pid, last,
        output ready
    );
endinterface

interface nvps_victim_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  found;
    logic [nvps_pkg::PID_BITS-1:0]         victim_pid;
    logic [nvps_pkg::VICTIM_PAGE_BITS-1:0] victim_page;
    logic [nvps_pkg::ENTRY_BITS-1:0]       new_entry;

    modport source (
        output valid, found, victim_pid, victim_page, new_entry,
        input  ready
    );
    modport sink (
        input  valid, found, victim_pid, victim_page, new_entry,
        output ready
    );
endinterface

FILE: rtl/nru_victim_page_select_top.sv
// NRU victim page select.
// scan (sink): one page-table entry per transaction with owner pid/state,
//   page number, raw entry, requester pid and last. Accepted on valid&ready.
// victim (source): one result per scan, issued for the transaction with last=1:
//   found, victim pid, page, and the entry with present cleared, swapped set.
// cfg_we/cfg_wdata: writes reserved_pid_limit; write only while idle.
// Timing: a transaction waits in the input register, where it is
//   filtered and folded into the slots; a last transaction loads the output
//   register when it advances, and victim.valid is driven from that register.
// Throughput: one transaction per cycle barring stalls; the input register
//   and slot update are one combinational pass; the output register decouples.
// Stall: while a result waits on victim.ready, non-last transactions keep
//   flowing; a last transaction waits in the input register until the output
//   register frees, and scan.ready stays low meanwhile.
// Reset: slots empty, limit = 5, both channels empty.
module nru_victim_page_select_top #(
    parameter int PAGE_NUMBER_BITS = nvps_pkg::PAGE_NUMBER_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [nvps_pkg::PID_BITS-1:0] cfg_wdata,
    nvps_scan_if.sink                     scan,
    nvps_victim_if.source                 victim
);

    localparam int VPB = nvps_pkg::VICTIM_PAGE_BITS;

    logic [nvps_pkg::PID_BITS-1:0]   limit_reg;

    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    logic [nvps_pkg::PID_BITS-1:0]   s1_pid_reg;
    logic [nvps_pkg::STATE_BITS-1:0] s1_state_reg;
    logic [PAGE_NUMBER_BITS-1:0]     s1_page_reg;
    logic [nvps_pkg::ENTRY_BITS-1:0] s1_entry_reg;
    logic [nvps_pkg::PID_BITS-1:0]   s1_req_reg;
    logic                            s1_last_reg;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            out_found_reg;
    logic [nvps_pkg::PID_BITS-1:0]   out_pid_reg;
    logic [VPB-1:0]                  out_page_reg;
    logic [nvps_pkg::ENTRY_BITS-1:0] out_entry_reg;

    logic                            adv;
    logic                            take;
    nvps_pkg::filt_t                 filt;
    logic                            sel_found;
    logic [nvps_pkg::PID_BITS-1:0]   sel_pid;
    logic [PAGE_NUMBER_BITS-1:0]     sel_page;
    logic [nvps_pkg::ENTRY_BITS-1:0] sel_entry;
    logic [PAGE_NUMBER_BITS+VPB-1:0] page_ext;
    logic [nvps_pkg::ENTRY_BITS-1:0] entry_fix;

    assign adv         = s1_valid_reg && (!s1_last_reg || !out_valid_reg || victim.ready);
    assign scan.ready  = !s1_valid_reg || adv;
    assign take        = scan.valid && scan.ready;

    nvps_filter u_filter (
        .limit         (limit_reg),
        .owner_pid     (s1_pid_reg),
        .owner_state   (s1_state_reg),
        .entry_word    (s1_entry_reg),
        .requester_pid (s1_req_reg),
        .filt          (filt)
    );

    nvps_slots #(
        .PAGE_BITS (PAGE_NUMBER_BITS)
    ) u_slots (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (adv),
        .last      (s1_last_reg),
        .filt      (filt),
        .pid       (s1_pid_reg),
        .page      (s1_page_reg),
        .entry     (s1_entry_reg),
        .sel_found (sel_found),
        .sel_pid   (sel_pid),
        .sel_page  (sel_page),
        .sel_entry (sel_entry)
    );

    always_comb
    begin
        page_ext  = {{VPB{1'b0}}, sel_page};
        entry_fix = sel_entry;
        entry_fix[nvps_pkg::ENT_PRESENT_BIT] = 1'b0;
        entry_fix[nvps_pkg::ENT_SWAPPED_BIT] = 1'b1;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (adv && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (victim.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= nvps_pkg::RESERVED_PID_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_pid_reg   <= scan.owner_pid;
            s1_state_reg <= scan.owner_state;
            s1_page_reg  <= scan.page_number;
            s1_entry_reg <= scan.entry_word;
            s1_req_reg   <= scan.requester_pid;
            s1_last_reg  <= scan.last;
        end
        if (adv && s1_last_reg)
        begin
            out_found_reg <= sel_found;
            out_pid_reg   <= sel_found ? sel_pid : '0;
            out_page_reg  <= sel_found ? page_ext[VPB-1:0] : '0;
            out_entry_reg <= sel_found ? entry_fix : '0;
        end
    end

    assign victim.valid       = out_valid_reg;
    assign victim.found       = out_found_reg;
    assign victim.victim_pid  = out_pid_reg;
    assign victim.victim_page = out_page_reg;
    assign victim.new_entry   = out_entry_reg;

endmodule

FILE: rtl/nvps_filter.sv
module nvps_filter (
    input  logic [nvps_pkg::PID_BITS-1:0]   limit,
    input  logic [nvps_pkg::PID_BITS-1:0]   owner_pid,
    input  logic [nvps_pkg::STATE_BITS-1:0] owner_state,
    input  logic [nvps_pkg::ENTRY_BITS-1:0] entry_word,
    input  logic [nvps_pkg::PID_BITS-1:0]   requester_pid,
    output nvps_pkg::filt_t                 filt
);

    logic state_ok;
    logic pid_ok;
    logic entry_ok;

    always_comb
    begin
        state_ok = (owner_state != nvps_pkg::ST_UNUSED) &&
                   (owner_state != nvps_pkg::ST_EMBRYO) &&
                   (owner_state != nvps_pkg::ST_RUNNING);
        pid_ok   = (owner_pid >= limit) && (owner_pid != requester_pid);
        entry_ok = entry_word[nvps_pkg::ENT_PRESENT_BIT] && entry_word[nvps_pkg::ENT_USER_BIT];
        filt.eligible = state_ok && pid_ok && entry_ok;
        // class = 2*accessed + dirty
        filt.cls = {entry_word[nvps_pkg::ENT_ACCESSED_BIT], entry_word[nvps_pkg::ENT_DIRTY_BIT]};
    end

endmodule

FILE: rtl/nvps_slots.sv
module nvps_slots #(
    parameter int PAGE_BITS = nvps_pkg::PAGE_NUMBER_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            upd,
    input  logic                            last,
    input  nvps_pkg::filt_t                 filt,
    input  logic [nvps_pkg::PID_BITS-1:0]   pid,
    input  logic [PAGE_BITS-1:0]            page,
    input  logic [nvps_pkg::ENTRY_BITS-1:0] entry,
    output logic                            sel_found,
    output logic [nvps_pkg::PID_BITS-1:0]   sel_pid,
    output logic [PAGE_BITS-1:0]            sel_page,
    output logic [nvps_pkg::ENTRY_BITS-1:0] sel_entry
);

    localparam int N = nvps_pkg::NUM_CLASSES;

    logic [N-1:0]                    valid_reg;
    logic [N-1:0]                    valid_next;
    logic [nvps_pkg::PID_BITS-1:0]   pid_reg   [N];
    logic [PAGE_BITS-1:0]            page_reg  [N];
    logic [nvps_pkg::ENTRY_BITS-1:0] entry_reg [N];

    logic [N-1:0]                    hit;
    logic [N-1:0]                    mv;
    logic [nvps_pkg::PID_BITS-1:0]   mpid   [N];
    logic [PAGE_BITS-1:0]            mpage  [N];
    logic [nvps_pkg::ENTRY_BITS-1:0] mentry [N];

    // merged view: stored slots with the current transaction folded in
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            hit[k]    = filt.eligible && (filt.cls == k[nvps_pkg::CLASS_BITS-1:0]);
            mv[k]     = valid_reg[k] || hit[k];
            mpid[k]   = hit[k] ? pid   : pid_reg[k];
            mpage[k]  = hit[k] ? page  : page_reg[k];
            mentry[k] = hit[k] ? entry : entry_reg[k];
        end
    end

    always_comb
    begin
        sel_found = 1'b0;
        sel_pid   = '0;
        sel_page  = '0;
        sel_entry = '0;
        for (int k = N - 1; k >= 0; k--)
        begin
            if (mv[k])
            begin
                sel_found = 1'b1;
                sel_pid   = mpid[k];
                sel_page  = mpage[k];
                sel_entry = mentry[k];
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (upd)
        begin
            valid_next = last ? '0 : mv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            if (upd && hit[k])
            begin
                pid_reg[k]   <= pid;
                page_reg[k]  <= page;
                entry_reg[k] <= entry;
            end
        end
    end

endmodule

FILE: sim/nru_victim_page_select_top_tb.sv
module nru_victim_page_select_top_tb;

    localparam int PAGE_BITS      = nvps_pkg::PAGE_NUMBER_BITS_DEF;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int ITEMS_PER_PASS = 84;
    localparam int NUM_PASSES     = 9;
    localparam int DRAIN_CYCLES   = 8;

    localparam logic [nvps_pkg::STATE_BITS-1:0] ST_SLEEPING = 3'd2;
    localparam logic [nvps_pkg::STATE_BITS-1:0] ST_RUNNABLE = 3'd3;
    localparam logic [nvps_pkg::STATE_BITS-1:0] ST_ZOMBIE   = 3'd5;
    localparam logic [nvps_pkg::STATE_BITS-1:0] ST_ODD6     = 3'd6;
    localparam logic [nvps_pkg::STATE_BITS-1:0] ST_ODD7     = 3'd7;

    localparam int LIM_RANDOM = -1;
    localparam int LIM_SMALL  = -2;

    typedef struct {
        logic [nvps_pkg::PID_BITS-1:0]   pid;
        logic [nvps_pkg::STATE_BITS-1:0] state;
        logic [PAGE_BITS-1:0]            page;
        logic [nvps_pkg::ENTRY_BITS-1:0] entry;
        logic [nvps_pkg::PID_BITS-1:0]   req;
        logic                            last;
    } scan_item_t;

    typedef struct {
        logic                                  found;
        logic [nvps_pkg::PID_BITS-1:0]         pid;
        logic [nvps_pkg::VICTIM_PAGE_BITS-1:0] page;
        logic [nvps_pkg::ENTRY_BITS-1:0]       entry;
    } victim_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [nvps_pkg::PID_BITS-1:0] cfg_wdata;

    nvps_scan_if #(.PAGE_BITS(PAGE_BITS)) scan_ch ();
    nvps_victim_if victim_ch ();

    nru_victim_page_select_top #(
        .PAGE_NUMBER_BITS(PAGE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .scan      (scan_ch),
        .victim    (victim_ch)
    );

    scan_item_t pending_scan[$];
    victim_t    victim_expq[$];
    scan_item_t in_flight;

    logic [nvps_pkg::PID_BITS-1:0]   pid_floor;
    logic                            cls_valid [nvps_pkg::NUM_CLASSES];
    logic [nvps_pkg::PID_BITS-1:0]   cls_pid   [nvps_pkg::NUM_CLASSES];
    logic [PAGE_BITS-1:0]            cls_page  [nvps_pkg::NUM_CLASSES];
    logic [nvps_pkg::ENTRY_BITS-1:0] cls_entry [nvps_pkg::NUM_CLASSES];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("[%0d] victim %s: got %0h expected %0h", cycles, what, got, want);
        mismatches++;
    endtask

    function automatic void clear_classes();
        for (int k = 0; k < nvps_pkg::NUM_CLASSES; k++)
        begin
            cls_valid[k] = 1'b0;
            cls_pid[k]   = '0;
            cls_page[k]  = '0;
            cls_entry[k] = '0;
        end
    endfunction

    // NRU slot update for one accepted transaction; queues the victim on last
    function automatic void nru_update(scan_item_t it);
        logic [nvps_pkg::CLASS_BITS-1:0] c;
        logic ok;
        victim_t v;
        ok = (it.state != nvps_pkg::ST_UNUSED) && (it.state != nvps_pkg::ST_EMBRYO)
            && (it.state != nvps_pkg::ST_RUNNING)
            && (it.pid >= pid_floor) && (it.pid != it.req)
            && it.entry[nvps_pkg::ENT_USER_BIT] && it.entry[nvps_pkg::ENT_PRESENT_BIT];
        if (ok)
        begin
            c = {it.entry[nvps_pkg::ENT_ACCESSED_BIT], it.entry[nvps_pkg::ENT_DIRTY_BIT]};
            cls_valid[c] = 1'b1;
            cls_pid[c]   = it.pid;
            cls_page[c]  = it.page;
            cls_entry[c] = it.entry;
        end
        if (it.last)
        begin
            v = '{found: 1'b0, pid: '0, page: '0, entry: '0};
            for (int k = nvps_pkg::NUM_CLASSES - 1; k >= 0; k--)
            begin
                if (cls_valid[k])
                begin
                    v.found = 1'b1;
                    v.pid   = cls_pid[k];
                    v.page  = cls_page[k];
                    v.entry = cls_entry[k];
                    v.entry[nvps_pkg::ENT_PRESENT_BIT] = 1'b0;
                    v.entry[nvps_pkg::ENT_SWAPPED_BIT] = 1'b1;
                end
            end
            victim_expq.push_back(v);
            clear_classes();
        end
    endfunction

    task automatic push_item(int pid, int st, int page, longint entry, int req, bit last);
        scan_item_t it;
        it.pid   = nvps_pkg::PID_BITS'(pid);
        it.state = nvps_pkg::STATE_BITS'(st);
        it.page  = PAGE_BITS'(page);
        it.entry = nvps_pkg::ENTRY_BITS'(entry);
        it.req   = nvps_pkg::PID_BITS'(req);
        it.last  = last;
        pending_scan.push_back(it);
    endtask

    function automatic scan_item_t rand_item(logic is_last);
        scan_item_t it;
        int sel;
        sel = $urandom_range(3);
        if (sel == 0)
            it.pid = nvps_pkg::PID_BITS'(pid_floor + $urandom_range(2) - 1);
        else if (sel == 1)
            it.pid = $urandom_range(1) ? '1 : '0;
        else
            it.pid = nvps_pkg::PID_BITS'($urandom);
        it.state = nvps_pkg::STATE_BITS'($urandom_range(7));
        sel = $urandom_range(7);
        it.page = (sel == 0) ? '0 : (sel == 1) ? '1 : PAGE_BITS'($urandom);
        it.entry = $urandom;
        if ($urandom_range(4) != 0)
        begin
            it.entry[nvps_pkg::ENT_PRESENT_BIT] = 1'b1;
            it.entry[nvps_pkg::ENT_USER_BIT]    = 1'b1;
        end
        it.req  = ($urandom_range(3) == 0) ? it.pid : nvps_pkg::PID_BITS'($urandom);
        it.last = is_last;
        return it;
    endfunction

    task automatic gen_scans(int n);
        int count;
        int len;
        scan_item_t it;
        count = 0;
        while (count < n)
        begin
            if ($urandom_range(9) == 0)
            begin
                it = rand_item(1'($urandom_range(1)));
                it.entry = $urandom;
                pending_scan.push_back(it);
                count++;
            end
            else
            begin
                len = ($urandom_range(15) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    pending_scan.push_back(rand_item(i == len - 1));
                count += len;
            end
        end
    endtask

    task automatic drain();
        while (pending_scan.size() != 0 || scan_ch.valid || victim_expq.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_floor(logic [nvps_pkg::PID_BITS-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pid_floor = v;
        @(negedge clk);
    endtask

    // scan driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (scan_ch.valid && scan_ch.ready)
                nru_update(in_flight);
            if (!scan_ch.valid || scan_ch.ready)
            begin
                if (pending_scan.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_flight = pending_scan.pop_front();
                    scan_ch.owner_pid     <= in_flight.pid;
                    scan_ch.owner_state   <= in_flight.state;
                    scan_ch.page_number   <= in_flight.page;
                    scan_ch.entry_word    <= in_flight.entry;
                    scan_ch.requester_pid <= in_flight.req;
                    scan_ch.last          <= in_flight.last;
                    scan_ch.valid         <= 1'b1;
                end
                else
                    scan_ch.valid <= 1'b0;
            end
        end
    end

    // victim monitor
    always @(posedge clk)
    begin
        victim_t want;
        if (rst_n)
        begin
            if (victim_ch.valid && victim_ch.ready)
            begin
                if (victim_expq.size() == 0)
                    report_mismatch("unexpected transaction", victim_ch.found, 0);
                else
                begin
                    want = victim_expq.pop_front();
                    if (victim_ch.found !== want.found)
                        report_mismatch("found", victim_ch.found, want.found);
                    if (victim_ch.victim_pid !== want.pid)
                        report_mismatch("pid", victim_ch.victim_pid, want.pid);
                    if (victim_ch.victim_page !== want.page)
                        report_mismatch("page", victim_ch.victim_page, want.page);
                    if (victim_ch.new_entry !== want.entry)
                        report_mismatch("new_entry", victim_ch.new_entry, want.entry);
                end
            end
            victim_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int pass_lim [NUM_PASSES];
        int lim;
        pass_lim = '{0, 65535, LIM_SMALL, 5, LIM_RANDOM, 65535, LIM_SMALL, 0, 1};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        scan_ch.valid = 1'b0;
        scan_ch.owner_pid = '0;
        scan_ch.owner_state = '0;
        scan_ch.page_number = '0;
        scan_ch.entry_word = '0;
        scan_ch.requester_pid = '0;
        scan_ch.last = 1'b0;
        victim_ch.ready = 1'b0;
        mismatches = 0;
        cycles = 0;
        pid_floor = nvps_pkg::RESERVED_PID_RESET;
        clear_classes();
        send_idle_pct = 24;
        recv_idle_pct = 74;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty scan, ineligible last
        push_item(7, ST_SLEEPING, 0, 0, 1, 1);
        // one per class, then every exclusion, eligible last lands in class 0
        push_item(10, ST_RUNNABLE, 20'hFFFFF, 32'hFFFFFFFF, 1, 0);
        push_item(65535, ST_ZOMBIE, 1, 32'h25, 1, 0);
        push_item(5, ST_ODD6, 2, 32'h45, 1, 0);
        push_item(6, ST_ODD7, 3, 32'h5, 1, 0);
        push_item(11, nvps_pkg::ST_UNUSED, 4, 32'h5, 1, 0);
        push_item(12, nvps_pkg::ST_EMBRYO, 5, 32'h5, 1, 0);
        push_item(13, nvps_pkg::ST_RUNNING, 6, 32'h5, 1, 0);
        push_item(4, ST_SLEEPING, 7, 32'h5, 1, 0);
        push_item(14, ST_SLEEPING, 8, 32'h5, 14, 0);
        push_item(15, ST_SLEEPING, 9, 32'h4, 1, 0);
        push_item(16, ST_SLEEPING, 10, 32'h1, 1, 0);
        push_item(9, ST_SLEEPING, 0, 32'hFFFFFF9F, 1, 1);
        // class 3 only, ineligible last
        push_item(20, ST_SLEEPING, 20'h12345, 32'h7F, 1, 0);
        push_item(0, ST_SLEEPING, 20'h54321, 32'h5, 65535, 1);
        // excluded-only scan
        push_item(30, nvps_pkg::ST_RUNNING, 20'hABCDE, 32'hFFFFFFFF, 0, 0);
        push_item(30, ST_ZOMBIE, 20'hABCDE, 32'h5, 30, 1);
        drain();

        for (int p = 0; p < NUM_PASSES; p++)
        begin
            unique case (p / 3)
                0:
                begin
                    send_idle_pct = 24;
                    recv_idle_pct = 74;
                end
                1:
                begin
                    send_idle_pct = 74;
                    recv_idle_pct = 24;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (pass_lim[p] == LIM_RANDOM)
                lim = $urandom_range(65535);
            else if (pass_lim[p] == LIM_SMALL)
                lim = $urandom_range(1, 64);
            else
                lim = pass_lim[p];
            write_floor(nvps_pkg::PID_BITS'(lim));
            gen_scans(ITEMS_PER_PASS);
            drain();
        end

        if (victim_expq.size() != 0)
            report_mismatch("missing transactions", 0, victim_expq.size());
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
